/* sv/wcs_pkg.sv */
package wcs_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int WEIGHT_BITS = 16;

  localparam int IDX_W     = $clog2(MAX_ENTRIES);
  localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int TOTAL_W   = WEIGHT_BITS + IDX_W;
  localparam int IN_W_W    = 16;
  localparam int FRAC_W    = 17;
  localparam int Q_BITS    = 16;
  localparam int TARGET_W  = FRAC_W + TOTAL_W;
  localparam int STATUS_W  = 3;
  localparam int OUT_IDX_W = 6;

  localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(65536);

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STS_ADDED = 3'd0;
  localparam logic [STATUS_W-1:0] STS_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NONE  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_RANGE = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FULL  = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_WALK,
    S_DONE
  } state_t;

  // query token moving down the cell row
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [IDX_W-1:0]   index;
    logic [TOTAL_W-1:0] prefix;
  } tok_t;

endpackage

/* sv/wcs_in_if.sv */
interface wcs_in_if;
  import wcs_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [IN_W_W-1:0] weight;
  logic [FRAC_W-1:0] fraction;

  modport source (output valid, output cmd, output weight, output fraction, input ready);
  modport sink (input valid, input cmd, input weight, input fraction, output ready);
endinterface

/* sv/wcs_out_if.sv */
interface wcs_out_if;
  import wcs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [OUT_IDX_W-1:0] index;

  modport source (output valid, output status, output index, input ready);
  modport sink (input valid, input status, input index, output ready);
endinterface

/* sv/wcs_cell.sv */
module wcs_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [wcs_pkg::WEIGHT_BITS-1:0] wr_weight,
  input  logic                           live,
  input  logic [wcs_pkg::IDX_W-1:0]       cell_id,
  input  logic [wcs_pkg::TARGET_W-1:0]    target,
  input  wcs_pkg::tok_t                  tok_in,
  output wcs_pkg::tok_t                  tok_out
);
  import wcs_pkg::*;

  logic [WEIGHT_BITS-1:0] weight_r;
  logic [TOTAL_W-1:0]     sum;
  logic [TARGET_W-1:0]    scaled;
  tok_t                   tok_r;
  tok_t                   tok_nxt;

  assign sum    = tok_in.prefix + TOTAL_W'(weight_r);
  assign scaled = TARGET_W'({sum, {Q_BITS{1'b0}}});

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.found && live) begin
      tok_nxt.prefix = sum;
      if (target <= scaled) begin
        tok_nxt.found = 1'b1;
        tok_nxt.index = cell_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      weight_r <= wr_weight;
    end
  end

  assign tok_out = tok_r;

endmodule

/* sv/weighted_cumulative_selector.sv */
// channel | dir | payload                   | beat
// in_ch   | in  | cmd, weight, fraction     | valid & ready
// out_ch  | out | status, index             | valid & ready
//
// an add or a rejected query goes from accept straight to the done state,
// which loads the output register; a searched query goes through launch and walk first: the token steps
// through one cell per cycle over the whole row
// one item at a time; the next beat is taken once the result sits in the
// output register, even while out_ch is stalled
// synchronous active-low reset clears the count, the total and all valid bits
module weighted_cumulative_selector (
  input logic       clk,
  input logic       rst_n,
  wcs_in_if.sink    in_ch,
  wcs_out_if.source out_ch
);
  import wcs_pkg::*;

  state_t               state_r;
  state_t               state_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [TOTAL_W-1:0]   total_r;
  logic [TOTAL_W-1:0]   total_nxt;
  logic [TARGET_W-1:0]  target_r;
  logic [TARGET_W-1:0]  target_nxt;
  logic [STATUS_W-1:0]  res_status_r;
  logic [STATUS_W-1:0]  res_status_nxt;
  logic [IDX_W-1:0]     res_index_r;
  logic [IDX_W-1:0]     res_index_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r;
  logic [STATUS_W-1:0]  out_status_nxt;
  logic [OUT_IDX_W-1:0] out_index_r;
  logic [OUT_IDX_W-1:0] out_index_nxt;

  logic                   accept;
  logic                   is_full;
  logic                   is_range;
  logic                   is_empty;
  logic                   append_go;
  logic                   out_free;
  logic [WEIGHT_BITS-1:0] wr_weight;
  logic [MAX_ENTRIES-1:0] live;
  logic [MAX_ENTRIES-1:0] wr_en;
  logic [MAX_ENTRIES-1:0] tok_busy;
  tok_t                   chain [0:MAX_ENTRIES];

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_full     = (count_r >= CNT_W'(MAX_ENTRIES));
  assign is_range    = (in_ch.fraction > ONE_Q16);
  assign is_empty    = (total_r == '0) || (count_r == '0);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign wr_weight   = WEIGHT_BITS'(in_ch.weight);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.cmd == CMD_ADD || is_range || is_empty) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LAUNCH;
          end
        end
      end
      S_LAUNCH: state_nxt = S_WALK;
      S_WALK: begin
        if (chain[MAX_ENTRIES].valid) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt      = count_r;
    total_nxt      = total_r;
    target_nxt     = target_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    append_go      = 1'b0;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_index_nxt = '0;
          if (in_ch.cmd == CMD_ADD) begin
            if (is_full) begin
              res_status_nxt = STS_FULL;
            end else begin
              append_go      = 1'b1;
              count_nxt      = count_r + CNT_W'(1);
              total_nxt      = total_r + TOTAL_W'(wr_weight);
              res_status_nxt = STS_ADDED;
            end
          end else if (is_range) begin
            res_status_nxt = STS_RANGE;
          end else if (is_empty) begin
            res_status_nxt = STS_NONE;
          end else begin
            target_nxt = TARGET_W'(in_ch.fraction) * TARGET_W'(total_r);
          end
        end
      end
      S_WALK: begin
        if (chain[MAX_ENTRIES].valid) begin
          if (chain[MAX_ENTRIES].found) begin
            res_status_nxt = STS_FOUND;
            res_index_nxt  = chain[MAX_ENTRIES].index;
          end else begin
            res_status_nxt = STS_NONE;
            res_index_nxt  = '0;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = OUT_IDX_W'(res_index_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r     <= target_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.index  = out_index_r;

  // token head
  assign chain[0] = tok_t'{valid: (state_r == S_LAUNCH), default: '0};

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign live[i]     = (CNT_W'(i) < count_r);
    assign wr_en[i]    = append_go && (count_r == CNT_W'(i));
    assign tok_busy[i] = chain[i + 1].valid;

    wcs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (wr_en[i]),
      .wr_weight (wr_weight),
      .live      (live[i]),
      .cell_id   (IDX_W'(i)),
      .target    (target_r),
      .tok_in    (chain[i]),
      .tok_out   (chain[i + 1])
    );
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count past table size");

  a_idle_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (tok_busy == '0))
    else $error("input taken while a query token is in the row");

  a_walk_finds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && chain[MAX_ENTRIES].valid) |-> chain[MAX_ENTRIES].found)
    else $error("query with nonzero total left the row unmatched");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");
`endif

endmodule
